@@ rtl/pcsp_pkg.sv @@
package pcsp_pkg;

  localparam int CAND_W  = 14;               // candidate and bound width
  localparam int DIV_W   = 8;                // trial divisor, reaches 128
  localparam int CNT_W   = 11;
  localparam int SUM_W   = 24;
  localparam int PROD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int PPROD_W = HALF_W + CAND_W;  // one partial product
  localparam int BIT_W   = $clog2(CAND_W);   // remainder step counter
  localparam int PC_W    = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 104;

  typedef logic [PC_W-1:0] upc_t;

  // datapath actions
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_NEXT_CAND,
    OP_DIV_START,
    OP_DIV_NEXT,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_CAND_DONE,
    C_CAND_LT2,
    C_SQ_GT,
    C_REM_BUSY,
    C_REM_ZERO,
    C_OUT_BUSY
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } uword_t;

  // step addresses
  localparam upc_t UA_WAIT     = 4'd0;
  localparam upc_t UA_CHK      = 4'd1;
  localparam upc_t UA_NEXT     = 4'd2;
  localparam upc_t UA_TEST     = 4'd3;
  localparam upc_t UA_TRY      = 4'd4;
  localparam upc_t UA_DIV      = 4'd5;
  localparam upc_t UA_WAITR    = 4'd6;
  localparam upc_t UA_CHKREM   = 4'd7;
  localparam upc_t UA_DIV_NEXT = 4'd8;
  localparam upc_t UA_MUL_LO   = 4'd9;
  localparam upc_t UA_MUL_HI   = 4'd10;
  localparam upc_t UA_HOLD     = 4'd11;
  localparam upc_t UA_EMIT     = 4'd12;

  // control store: execute op, then jump to target if cond holds, else step on
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      UA_WAIT:     w = '{OP_LOAD,      C_NO_REQ,    UA_WAIT};
      UA_CHK:      w = '{OP_NOP,       C_CAND_DONE, UA_HOLD};
      UA_NEXT:     w = '{OP_NEXT_CAND, C_NEVER,     UA_WAIT};
      UA_TEST:     w = '{OP_NOP,       C_CAND_LT2,  UA_CHK};
      UA_TRY:      w = '{OP_NOP,       C_SQ_GT,     UA_MUL_LO};
      UA_DIV:      w = '{OP_DIV_START, C_NEVER,     UA_WAIT};
      UA_WAITR:    w = '{OP_NOP,       C_REM_BUSY,  UA_WAITR};
      UA_CHKREM:   w = '{OP_NOP,       C_REM_ZERO,  UA_CHK};
      UA_DIV_NEXT: w = '{OP_DIV_NEXT,  C_ALWAYS,    UA_TRY};
      UA_MUL_LO:   w = '{OP_MUL_LO,    C_NEVER,     UA_WAIT};
      UA_MUL_HI:   w = '{OP_MUL_HI,    C_ALWAYS,    UA_CHK};
      UA_HOLD:     w = '{OP_NOP,       C_OUT_BUSY,  UA_HOLD};
      UA_EMIT:     w = '{OP_EMIT,      C_ALWAYS,    UA_WAIT};
      default:     w = '{OP_NOP,       C_ALWAYS,    UA_WAIT};
    endcase
    return w;
  endfunction

  typedef struct packed {
    logic              start;
    logic [CAND_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] rem;
  } rem_rsp_t;

endpackage

@@ rtl/pcsp_rem.sv @@
module pcsp_rem import pcsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy_r;
  logic [BIT_W-1:0]  cnt_r;
  logic [CAND_W-1:0] dvd_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W-1:0]  rem_r;

  logic [DIV_W:0] sh;
  logic [DIV_W:0] diff;
  logic           ge;

  // restoring remainder, one dividend bit per cycle
  assign sh   = {rem_r, dvd_r[CAND_W-1]};
  assign ge   = (sh >= {1'b0, dsr_r});
  assign diff = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= BIT_W'(CAND_W - 1);
      dvd_r  <= req.dividend;
      dsr_r  <= req.divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      dvd_r <= {dvd_r[CAND_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/prime_count_sum_product.sv @@
// Channel  Dir  Ports                         Payload
// in       in   in_tvalid/in_tready/in_tdata  n
// out      out  out_tvalid/out_tready/        prime_count, prime_sum, prime_product,
//               out_tdata/out_tuser           product_overflow
//
// One request at a time; a small control store steps a candidate counter, a trial
// divisor and a bit-serial remainder unit. Each prime also takes a last divisor test
// and the split 64x14 multiply. Composites stop at their smallest factor.
// Reset (rst_n low, synchronous) returns to waiting with no result pending.
// The result register holds while out_tready is low; a new bound is taken meanwhile.
module prime_count_sum_product import pcsp_pkg::*; #(
  parameter int MAX_BOUND = 16383
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [13:0] n
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] prime_count, [34:11] prime_sum,
                                            // [98:35] prime_product
  output logic [0:0]            out_tuser   // [0] product_overflow
);

  localparam logic [CAND_W-1:0] SAT_BOUND = CAND_W'(MAX_BOUND);

  upc_t   pc_r, pc_nxt;
  uword_t uw;
  logic   jump;
  logic   in_acc;

  logic [CAND_W-1:0]  limit_r;
  logic [CAND_W-1:0]  cand_r;
  logic [DIV_W-1:0]   div_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PROD_W-1:0]  prod_r;
  logic               ovf_r;
  logic [PPROD_W-1:0] lo_r;
  logic [PPROD_W-1:0] hi_sum;
  logic [2*DIV_W-1:0] div_sq;

  logic               out_valid_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [PROD_W-1:0]  out_prod_r;
  logic               out_ovf_r;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  pcsp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign uw        = ucode(pc_r);
  assign in_tready = (pc_r == UA_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign div_sq    = (2*DIV_W)'(div_r) * (2*DIV_W)'(div_r);

  assign rem_req.start    = (uw.op == OP_DIV_START);
  assign rem_req.dividend = cand_r;
  assign rem_req.divisor  = div_r;

  // upper half of the product plus carry-in from the lower partial product
  assign hi_sum = PPROD_W'(prod_r[PROD_W-1:HALF_W]) * PPROD_W'(cand_r)
                + PPROD_W'(lo_r[PPROD_W-1:HALF_W]);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_REQ:    jump = !in_tvalid;
      C_CAND_DONE: jump = (cand_r == limit_r);
      C_CAND_LT2:  jump = (cand_r < CAND_W'(2));
      C_SQ_GT:     jump = (div_sq > (2*DIV_W)'(cand_r));
      C_REM_BUSY:  jump = rem_rsp.busy;
      C_REM_ZERO:  jump = (rem_rsp.rem == '0);
      C_OUT_BUSY:  jump = out_valid_r;
      default:     jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_acc) begin
          limit_r <= (32'(in_tdata[CAND_W-1:0]) > MAX_BOUND) ? SAT_BOUND
                                                             : in_tdata[CAND_W-1:0];
          cand_r  <= '0;
          count_r <= '0;
          sum_r   <= '0;
          prod_r  <= PROD_W'(1);
          ovf_r   <= 1'b0;
        end
      end
      OP_NEXT_CAND: begin
        cand_r <= cand_r + 1'b1;
        div_r  <= DIV_W'(2);
      end
      OP_DIV_NEXT: div_r <= div_r + 1'b1;
      OP_MUL_LO:   lo_r  <= PPROD_W'(prod_r[HALF_W-1:0]) * PPROD_W'(cand_r);
      OP_MUL_HI: begin
        prod_r  <= {hi_sum[HALF_W-1:0], lo_r[HALF_W-1:0]};
        ovf_r   <= ovf_r | (|hi_sum[PPROD_W-1:HALF_W]);
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUM_W'(cand_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
      out_count_r <= count_r;
      out_sum_r   <= sum_r;
      out_prod_r  <= prod_r;
      out_ovf_r   <= ovf_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CNT_W - SUM_W - PROD_W)'(0),
                       out_prod_r, out_sum_r, out_count_r};
  assign out_tuser  = out_ovf_r;

`ifndef ASSERT_OFF
  a_rem_busy_waits: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.busy |-> (pc_r == UA_WAITR))
    else $error("remainder unit busy outside its wait step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_EMIT) |-> !out_valid_r)
    else $error("result written over a pending result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == '0) |->
      (out_sum_r == '0 && out_prod_r == PROD_W'(1) && !out_ovf_r))
    else $error("no primes but nonempty sum or product");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    rem_req.start |-> (div_r >= DIV_W'(2) && cand_r >= CAND_W'(2)))
    else $error("trial division started with bad operands");
`endif

endmodule

@@ dv/prime_count_sum_product_test.sv @@
module prime_count_sum_product_test import pcsp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 12;
  localparam int BOUND_CAP     = 16383;
  localparam int RAND_REQS     = 85;
  localparam int DRAIN_CYCLES  = 64;
  // the slowest request is the directed bound n = 16383
  localparam int TIMEOUT_CYCLES = 40_000_000;

  typedef struct packed {
    logic              ovf;
    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
  } prime_totals_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  int unsigned   pending_bounds[$];
  prime_totals_t expected_totals[$];
  int            idle_left = 0;
  int            stall_left = 0;
  logic          calm = 1'b0;
  int            n_errors = 0;

  prime_count_sum_product #(
    .MAX_BOUND(BOUND_CAP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // count, sum and product of the primes in 1..n, product wrapping at 64 bits
  function automatic prime_totals_t tally_primes(logic [CAND_W-1:0] n);
    prime_totals_t t;
    int unsigned   lim;
    logic          is_prime;
    logic [127:0]  wide;
    t.count   = '0;
    t.sum     = '0;
    t.product = 64'd1;
    t.ovf     = 1'b0;
    lim = (n > BOUND_CAP) ? BOUND_CAP : n;
    for (int unsigned v = 2; v <= lim; v++) begin
      is_prime = 1'b1;
      for (int unsigned d = 2; d * d <= v; d++) begin
        if (v % d == 0) begin
          is_prime = 1'b0;
          break;
        end
      end
      if (is_prime) begin
        t.count = t.count + 1'b1;
        t.sum   = t.sum + SUM_W'(v);
        wide    = {64'd0, t.product} * 128'(v);
        if (wide[127:64] != '0) t.ovf = 1'b1;
        t.product = wide[63:0];
      end
    end
    return t;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  task automatic report_mismatch(string what, logic [PROD_W-1:0] got,
                                 logic [PROD_W-1:0] want);
    n_errors++;
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_totals.push_back(tally_primes(in_tdata[CAND_W-1:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (idle_left != 0) begin
          in_tvalid <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_bounds.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_DATA_W'(pending_bounds.pop_front());
          idle_left <= calm ? 0 : gap_cycles();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    prime_totals_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      calm       <= 1'b0;
    end else begin
      if ($urandom_range(0, 4095) == 0) calm <= ~calm;
      if (out_tvalid && out_tready) begin
        if (expected_totals.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[PROD_W-1:0], '0);
        end else begin
          want = expected_totals.pop_front();
          if (out_tdata[10:0] !== want.count)
            report_mismatch("prime_count", PROD_W'(out_tdata[10:0]),
                            PROD_W'(want.count));
          if (out_tdata[34:11] !== want.sum)
            report_mismatch("prime_sum", PROD_W'(out_tdata[34:11]),
                            PROD_W'(want.sum));
          if (out_tdata[98:35] !== want.product)
            report_mismatch("prime_product", out_tdata[98:35], want.product);
          if (out_tuser[0] !== want.ovf)
            report_mismatch("product_overflow", PROD_W'(out_tuser[0]),
                            PROD_W'(want.ovf));
        end
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_left <= gap_cycles();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    // empty range, first primes, product fits up to 47 and wraps from 53 on,
    // all-ones bound, repeated bound
    int unsigned directed[] = '{0, 1, 2, 3, 4, 5, 16, 47, 52, 53, 53, 97, 100, 255,
                                1024, 2047, 16383};
    foreach (directed[k]) pending_bounds.push_back(directed[k]);
    // keep bounds small: run time grows roughly as n^1.5
    for (int k = 0; k < RAND_REQS; k++) begin
      if (k % 50 == 17)
        pending_bounds.push_back($urandom_range(1024, 4095));
      else if (k % 12 == 5)
        pending_bounds.push_back($urandom_range(256, 1023));
      else
        pending_bounds.push_back($urandom_range(0, 255));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bounds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d results outstanding", expected_totals.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
